// ===== rtl/core/sdd_pkg.sv =====
package sdd_pkg;

  // field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DIFF_W  = 23;

  // internal widths
  localparam int DOY_W   = 9;   // day-of-year up to 365 + 1 + 31
  localparam int ABS_W   = 23;  // absolute day number of a date
  localparam int LEAP_W  = 13;  // leap days before a year
  localparam int QUOT_W  = 8;   // year / 100
  localparam int C400_W  = 6;   // ceil(year / 400)
  localparam int WIDE_W  = ABS_W + 2;

  // year / 100 by reciprocal: floor(y * 41944 / 2^22), exact for y < 2^15
  localparam int DIV100_MUL_W = 16;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 16'd41944;
  localparam int DIV100_SHIFT = 22;
  localparam int PROD_W = YEAR_W + DIV100_MUL_W;

  localparam int YEAR_DAYS = 365;
  localparam int CENTURY   = 100;

  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;

  localparam logic signed [WIDE_W-1:0] DIFF_MAX = 25'sd4194303;
  localparam logic signed [WIDE_W-1:0] DIFF_MIN = -25'sd4194304;

  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [DOY_W-1:0]   doy_t;
  typedef logic [ABS_W-1:0]   abs_day_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // load enables of the four pipeline stages
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } stage_en_t;

  // days in the months before the given one (non-leap); month 0 counts none,
  // months above twelve count the whole year
  function automatic doy_t cum_before(input month_t month);
    doy_t days;
    case (month)
      4'd0, 4'd1: days = 9'd0;
      4'd2:       days = 9'd31;
      4'd3:       days = 9'd59;
      4'd4:       days = 9'd90;
      4'd5:       days = 9'd120;
      4'd6:       days = 9'd151;
      4'd7:       days = 9'd181;
      4'd8:       days = 9'd212;
      4'd9:       days = 9'd243;
      4'd10:      days = 9'd273;
      4'd11:      days = 9'd304;
      4'd12:      days = 9'd334;
      default:    days = 9'd365;
    endcase
    return days;
  endfunction

endpackage

// ===== rtl/core/sdd_if.sv =====
// request channel: two dates and the include-end flag
interface sdd_in_if import sdd_pkg::*;;
  logic   valid;
  logic   ready;
  year_t  first_year;
  month_t first_month;
  day_t   first_day;
  year_t  second_year;
  month_t second_month;
  day_t   second_day;
  logic   include_end;

  modport source (
    output valid, first_year, first_month, first_day,
           second_year, second_month, second_day, include_end,
    input  ready
  );
  modport sink (
    input  valid, first_year, first_month, first_day,
           second_year, second_month, second_day, include_end,
    output ready
  );
endinterface

// result channel: signed day difference
interface sdd_out_if import sdd_pkg::*;;
  logic  valid;
  logic  ready;
  diff_t day_difference;

  modport source (
    output valid, day_difference,
    input  ready
  );
  modport sink (
    input  valid, day_difference,
    output ready
  );
endinterface

// ===== rtl/core/signed_date_difference_days_unit.sv =====
// Four register stages; stage one holds the year / 100 reciprocal multiply.
// Throughput: one request per cycle while the result side keeps taking;
// a stall holds every full stage in place, while empty stages still load.
// Reset: synchronous, active low; clears the stage valid bits only.
module signed_date_difference_days_unit import sdd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  sdd_in_if.sink   in_req,
  sdd_out_if.source out_res
);

  stage_en_t en;

  sdd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .en        (en)
  );

  year_t    y1_b, y2_b;
  doy_t     doy1_b, doy2_b;
  abs_day_t abs1_c, abs2_c;

  sdd_date_count u_first (
    .clk    (clk),
    .en     (en),
    .year   (in_req.first_year),
    .month  (in_req.first_month),
    .day    (in_req.first_day),
    .year_b (y1_b),
    .doy_b  (doy1_b),
    .abs_c  (abs1_c)
  );

  sdd_date_count u_second (
    .clk    (clk),
    .en     (en),
    .year   (in_req.second_year),
    .month  (in_req.second_month),
    .day    (in_req.second_day),
    .year_b (y2_b),
    .doy_b  (doy2_b),
    .abs_c  (abs2_c)
  );

  // include-end flag travels alongside the dates
  logic end_a_r, end_b_r, end_c_r;

  always_ff @(posedge clk) begin
    if (en.a) end_a_r <= in_req.include_end;
    if (en.b) end_b_r <= end_a_r;
    if (en.c) end_c_r <= end_b_r;
  end

  // stage c: order of the dates, years first
  logic earlier_c_r, earlier_c_nxt;

  assign earlier_c_nxt = (y1_b != y2_b) ? (y1_b < y2_b) : (doy1_b < doy2_b);

  always_ff @(posedge clk) begin
    if (en.c) earlier_c_r <= earlier_c_nxt;
  end

  // stage d: difference, end-day adjust, saturate
  logic signed [WIDE_W-1:0] adj;
  logic signed [WIDE_W-1:0] diff_wide;
  diff_t                    diff_r, diff_nxt;

  always_comb begin
    if (!end_c_r)         adj = '0;
    else if (earlier_c_r) adj = WIDE_W'(1);
    else                  adj = -WIDE_W'(1);
    diff_wide = $signed({2'b00, abs2_c}) - $signed({2'b00, abs1_c}) + adj;
    if (diff_wide > DIFF_MAX)      diff_nxt = DIFF_MAX[DIFF_W-1:0];
    else if (diff_wide < DIFF_MIN) diff_nxt = DIFF_MIN[DIFF_W-1:0];
    else                           diff_nxt = diff_wide[DIFF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.d) diff_r <= diff_nxt;
  end

  assign out_res.day_difference = diff_r;

  // result side taking means no stage can be blocked
  a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.ready |-> in_req.ready)
    else $error("request refused while result side is ready");

  // a held result must not be overwritten by the output stage
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !out_res.ready) |-> !en.d)
    else $error("output stage loads while result is stalled");

  // nothing leaves the pipeline straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("result valid after reset");

endmodule

// ===== rtl/core/sdd_pipe_ctrl.sv =====
module sdd_pipe_ctrl import sdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output stage_en_t en
);

  logic va_r, vb_r, vc_r, vd_r;
  logic va_nxt, vb_nxt, vc_nxt, vd_nxt;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  // a stage may load when it is empty or its contents move on
  assign rdy_d = !vd_r || out_ready;
  assign rdy_c = !vc_r || rdy_d;
  assign rdy_b = !vb_r || rdy_c;
  assign rdy_a = !va_r || rdy_b;

  assign en.a = rdy_a;
  assign en.b = rdy_b;
  assign en.c = rdy_c;
  assign en.d = rdy_d;

  assign in_ready  = rdy_a;
  assign out_valid = vd_r;

  always_comb begin
    va_nxt = rdy_a ? in_valid : va_r;
    vb_nxt = rdy_b ? va_r     : vb_r;
    vc_nxt = rdy_c ? vb_r     : vc_r;
    vd_nxt = rdy_d ? vc_r     : vd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
      vd_r <= vd_nxt;
    end
  end

endmodule

// ===== rtl/core/sdd_date_count.sv =====
module sdd_date_count import sdd_pkg::*; (
  input  logic      clk,
  input  stage_en_t en,
  input  year_t     year,
  input  month_t    month,
  input  day_t      day,
  output year_t     year_b,
  output doy_t      doy_b,
  output abs_day_t  abs_c
);

  // stage a: year / 100 product, month table lookup
  logic [PROD_W-1:0] prod_a_r, prod_a_nxt;
  year_t             year_a_r;
  doy_t              cum_a_r, cum_a_nxt;
  logic              late_a_r, late_a_nxt;
  day_t              day_a_r;

  assign prod_a_nxt = PROD_W'(year) * PROD_W'(DIV100_MUL);
  assign cum_a_nxt  = cum_before(month);
  assign late_a_nxt = (month >= MONTH_MAR);

  always_ff @(posedge clk) begin
    if (en.a) begin
      prod_a_r <= prod_a_nxt;
      year_a_r <= year;
      cum_a_r  <= cum_a_nxt;
      late_a_r <= late_a_nxt;
      day_a_r  <= day;
    end
  end

  // stage b: leap test, leap days before the year, day-of-year, 365 * year
  logic [QUOT_W-1:0] quot;
  year_t             quot_x100;
  logic              rem_nz;
  logic [QUOT_W-1:0] c100;
  logic [C400_W-1:0] c400;
  logic [LEAP_W-1:0] c4;
  logic              leap;

  logic [LEAP_W-1:0] leap_days_b_r, leap_days_b_nxt;
  doy_t              doy_b_r, doy_b_nxt;
  abs_day_t          y365_b_r, y365_b_nxt;
  year_t             year_b_r;

  always_comb begin
    quot      = prod_a_r[DIV100_SHIFT +: QUOT_W];
    quot_x100 = YEAR_W'(YEAR_W'(quot) * YEAR_W'(CENTURY));
    rem_nz    = (year_a_r != quot_x100);
    // ceilings of y/100, y/400 and y/4
    c100      = quot + QUOT_W'(rem_nz);
    c400      = C400_W'((10'(c100) + 10'd3) >> 2);
    c4        = LEAP_W'((15'(year_a_r) + 15'd3) >> 2);
    leap      = (year_a_r[1:0] == 2'b00) && (rem_nz || (quot[1:0] == 2'b00));

    leap_days_b_nxt = c4 - LEAP_W'(c100) + LEAP_W'(c400);
    doy_b_nxt       = cum_a_r + DOY_W'(day_a_r) + DOY_W'(late_a_r && leap);
    y365_b_nxt      = ABS_W'(ABS_W'(year_a_r) * ABS_W'(YEAR_DAYS));
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      leap_days_b_r <= leap_days_b_nxt;
      doy_b_r       <= doy_b_nxt;
      y365_b_r      <= y365_b_nxt;
      year_b_r      <= year_a_r;
    end
  end

  assign year_b = year_b_r;
  assign doy_b  = doy_b_r;

  // stage c: absolute day number
  abs_day_t abs_c_r, abs_c_nxt;

  assign abs_c_nxt = y365_b_r + ABS_W'(leap_days_b_r) + ABS_W'(doy_b_r);

  always_ff @(posedge clk) begin
    if (en.c) begin
      abs_c_r <= abs_c_nxt;
    end
  end

  assign abs_c = abs_c_r;

endmodule
